// ===== hdl/amn_pkg.sv =====
// ----------------------------------------------------------------------------
// amn_pkg
// shared types and codes for the ar archive mtime normalizer
// ----------------------------------------------------------------------------
package amn_pkg;

	// status codes carried with every output word
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
	localparam logic [1:0] ST_BAD_SIZE  = 2'd2;
	localparam logic [1:0] ST_TRUNC     = 2'd3;

	// one processed word as handed from the step logic to the result register
	typedef struct packed {
		logic [7:0] byte_val;
		logic [1:0] status;
		logic       last;
	} amn_result_t;

endpackage

// ===== hdl/amn_step.sv =====
// ----------------------------------------------------------------------------
// amn_step
// archive walker: phase tracking, mtime rewrite, size parse, magic check
// ----------------------------------------------------------------------------
module amn_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [7:0]           byte_in,
	input  logic                 is_last,
	output amn_pkg::amn_result_t result
);

	typedef enum logic [2:0] {
		PH_GMAG    = 3'd0,
		PH_NAME    = 3'd1,
		PH_MTIME   = 3'd2,
		PH_IDS     = 3'd3,
		PH_SIZE    = 3'd4,
		PH_FMAG    = 3'd5,
		PH_CONTENT = 3'd6,
		PH_STOP    = 3'd7
	} phase_t;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] MAGIC_0  = 8'h60;
	localparam logic [7:0] MAGIC_1  = 8'h0A;

	phase_t      phase_q, phase_n;
	logic [4:0]  pos_q, pos_n;
	logic [33:0] acc_q, acc_n;
	logic        seen_q, seen_n;
	logic        ended_q, ended_n;
	logic        err_q, err_n;
	logic [34:0] rem_q, rem_n;

	logic [7:0]  ob;
	logic [1:0]  st;
	logic        in_header;
	logic        header_end;
	logic        is_digit;
	logic [33:0] acc_mac;

	assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
	// acc * 10 + digit as two shifts and two adds, wraps at 34 bits
	assign acc_mac  = {acc_q[30:0], 3'b000} + {acc_q[32:0], 1'b0}
		+ {30'd0, byte_in[3:0]};

	always_comb begin
		phase_n    = phase_q;
		pos_n      = pos_q;
		acc_n      = acc_q;
		seen_n     = seen_q;
		ended_n    = ended_q;
		err_n      = err_q;
		rem_n      = rem_q;
		ob         = byte_in;
		st         = amn_pkg::ST_OK;
		in_header  = 1'b0;
		header_end = 1'b0;
		case (phase_q)
			PH_GMAG: begin
				if (pos_q >= 5'd7) begin
					phase_n = PH_NAME;
					pos_n   = 5'd0;
				end else begin
					pos_n = pos_q + 5'd1;
				end
			end
			PH_NAME: begin
				in_header = 1'b1;
				if (pos_q >= 5'd15) begin
					phase_n = PH_MTIME;
					pos_n   = 5'd0;
				end else begin
					pos_n = pos_q + 5'd1;
				end
			end
			PH_MTIME: begin
				in_header = 1'b1;
				ob = (pos_q == 5'd0) ? CH_ZERO : CH_SPACE;
				if (pos_q >= 5'd11) begin
					phase_n = PH_IDS;
					pos_n   = 5'd0;
				end else begin
					pos_n = pos_q + 5'd1;
				end
			end
			PH_IDS: begin
				in_header = 1'b1;
				if (pos_q >= 5'd19) begin
					phase_n = PH_SIZE;
					pos_n   = 5'd0;
					acc_n   = '0;
					seen_n  = 1'b0;
					ended_n = 1'b0;
					err_n   = 1'b0;
				end else begin
					pos_n = pos_q + 5'd1;
				end
			end
			PH_SIZE: begin
				in_header = 1'b1;
				if (!ended_q && !err_q) begin
					if (is_digit) begin
						acc_n  = acc_mac;
						seen_n = 1'b1;
					end else if (seen_q) begin
						ended_n = 1'b1;
					end else if (byte_in != CH_SPACE) begin
						err_n = 1'b1;
					end
				end
				if (pos_q >= 5'd9) begin
					pos_n = 5'd0;
					if (err_n || !seen_n) begin
						st      = amn_pkg::ST_BAD_SIZE;
						phase_n = PH_STOP;
					end else begin
						phase_n = PH_FMAG;
					end
				end else begin
					pos_n = pos_q + 5'd1;
				end
			end
			PH_FMAG: begin
				in_header = 1'b1;
				if (pos_q == 5'd0) begin
					if (byte_in != MAGIC_0) st = amn_pkg::ST_BAD_MAGIC;
					pos_n = 5'd1;
				end else begin
					header_end = 1'b1;
					if (byte_in != MAGIC_1) st = amn_pkg::ST_BAD_MAGIC;
					// content plus one pad byte when the size is odd
					rem_n   = {1'b0, acc_q} + {34'd0, acc_q[0]};
					pos_n   = 5'd0;
					phase_n = (rem_n != 35'd0) ? PH_CONTENT : PH_NAME;
				end
			end
			PH_CONTENT: begin
				rem_n = rem_q - 35'd1;
				if (rem_n == 35'd0) begin
					phase_n = PH_NAME;
					pos_n   = 5'd0;
				end
			end
			PH_STOP: begin
				phase_n = PH_STOP;
			end
			default: begin
				phase_n = PH_STOP;
			end
		endcase

		if (is_last && in_header && !header_end) st = amn_pkg::ST_TRUNC;

		// end of archive: start over for the next one
		if (is_last) begin
			phase_n = PH_GMAG;
			pos_n   = '0;
			acc_n   = '0;
			seen_n  = 1'b0;
			ended_n = 1'b0;
			err_n   = 1'b0;
			rem_n   = '0;
		end
	end

	assign result.byte_val = ob;
	assign result.status   = st;
	assign result.last     = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_GMAG;
			pos_q   <= '0;
			acc_q   <= '0;
			seen_q  <= 1'b0;
			ended_q <= 1'b0;
			err_q   <= 1'b0;
			rem_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			acc_q   <= acc_n;
			seen_q  <= seen_n;
			ended_q <= ended_n;
			err_q   <= err_n;
			rem_q   <= rem_n;
		end
	end

endmodule

// ===== hdl/ar_archive_mtime_normalizer.sv =====
// ----------------------------------------------------------------------------
// ar_archive_mtime_normalizer
// streams an ar archive byte by byte, blanking member mtimes and checking headers
// ----------------------------------------------------------------------------
// an accepted word passes the input register, then the result register, before out_valid rises
// throughput: one word per cycle, limited only by out_ready backpressure
// the archive walker state advances once per word in a single combinational pass
// reset (arst_n low): pipeline empty, walker back at the global magic
// a word with is_last set also returns the walker to its reset state
// ----------------------------------------------------------------------------
module ar_archive_mtime_normalizer (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_in,
	input  logic       is_last,
	// output channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] byte_out,
	output logic [1:0] status,
	output logic       last_out
);

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// result register stage
	logic                 valid_s2;
	amn_pkg::amn_result_t res_s2;

	amn_pkg::amn_result_t res_comb;

	logic s2_free;
	logic advance;

	// result slot can take a word if empty or being drained this cycle
	assign s2_free  = !valid_s2 || out_ready;
	// word in stage 1 is processed and moved on; walker state steps with it
	assign advance  = valid_s1 && s2_free;
	// stage 1 refills whenever it is empty or emptying
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= byte_in;
			last_s1 <= is_last;
		end
	end

	// header walker, rewrite and status on the stage 1 word
	amn_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_in (byte_s1),
		.is_last (last_s1),
		.result  (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid = valid_s2;
	assign byte_out  = res_s2.byte_val;
	assign status    = res_s2.status;
	assign last_out  = res_s2.last;

endmodule
